// File: rtl/speck128_block_cipher_top_assert.svh
// ----------------------------------------------------------------------------
// Speck128 assertion macros
// Shorthand for clocked assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPECK128_BLOCK_CIPHER_TOP_ASSERT_SVH
`define SPECK128_BLOCK_CIPHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/spk128_pkg.sv
// ----------------------------------------------------------------------------
// Speck128 package
// Widths, register indexes, item types and controller commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spk128_pkg;

  localparam int WORD_W            = 64;
  localparam int ROUNDS_DEFAULT    = 34;
  localparam int KEY_WORDS_DEFAULT = 4;
  localparam int ROUND_BASE        = 32;
  localparam int KEY_WORDS_BASE    = 2;
  localparam int KEY_REG_COUNT     = 4;
  localparam int KEY_SIZE_W        = 2;
  localparam int CFG_IDX_W         = 3;
  localparam int ROT_X             = 8;
  localparam int ROT_Y             = 3;

  localparam logic [KEY_SIZE_W-1:0] KEY_SIZE_MAX = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 3'd4;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] block_low;
    logic [WORD_W-1:0] block_high;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;
  } out_item_t;

  typedef struct packed {
    logic key_load;
    logic key_step;
    logic load_blk;
    logic round_en;
    logic dec;
  } dp_cmd_t;

endpackage

// File: rtl/spk128_ram.sv
// ----------------------------------------------------------------------------
// Speck128 generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spk128_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 34
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/spk128_datapath.sv
// ----------------------------------------------------------------------------
// Speck128 datapath
// Key registers, key schedule words, round-key RAM and the block round unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spk128_datapath #(
  parameter int MAX_ROUNDS          = spk128_pkg::ROUNDS_DEFAULT,
  parameter int MAX_KEY_WORDS_COUNT = spk128_pkg::KEY_WORDS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spk128_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [spk128_pkg::WORD_W-1:0]       cfg_wdata_i,
  input  spk128_pkg::dp_cmd_t                 cmd_i,
  input  logic [$clog2(MAX_ROUNDS)-1:0]       rd_addr_i,
  input  logic [$clog2(MAX_ROUNDS+1)-1:0]     key_idx_i,
  input  spk128_pkg::in_item_t                blk_i,
  output logic [spk128_pkg::KEY_SIZE_W-1:0]   key_sel_o,
  output spk128_pkg::out_item_t               result_o
);

  import spk128_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROUNDS);
  localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);
  localparam int WRD_W  = $clog2(MAX_KEY_WORDS_COUNT + 1);

  function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] v, input int n);
    rotr = (v >> n) | (v << (WORD_W - n));
  endfunction

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
    rotl = (v << n) | (v >> (WORD_W - n));
  endfunction

  logic [KEY_SIZE_W-1:0] ks_q;
  logic [WORD_W-1:0]     kw_q [KEY_REG_COUNT];
  logic [KEY_SIZE_W-1:0] key_sel;
  logic [WRD_W-1:0]      words;
  logic [WORD_W-1:0]     w_q [MAX_KEY_WORDS_COUNT];
  logic [WORD_W-1:0]     w_d [MAX_KEY_WORDS_COUNT];
  logic [WORD_W-1:0]     w_shift [MAX_KEY_WORDS_COUNT];
  logic [WORD_W-1:0]     ka;
  logic [WORD_W-1:0]     kb;
  logic [CNT_W-1:0]      kidx_inc;
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic [WORD_W-1:0]     rk;
  logic [WORD_W-1:0]     x_q, x_d, y_q, y_d;
  logic [WORD_W-1:0]     xe, ye, xd, yd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q <= '0;
      for (int i = 0; i < KEY_REG_COUNT; i++) begin
        kw_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEY_SIZE:  ks_q    <= cfg_wdata_i[KEY_SIZE_W-1:0];
        REG_KEY_WORD0: kw_q[0] <= cfg_wdata_i;
        REG_KEY_WORD1: kw_q[1] <= cfg_wdata_i;
        REG_KEY_WORD2: kw_q[2] <= cfg_wdata_i;
        REG_KEY_WORD3: kw_q[3] <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign key_sel   = (ks_q > KEY_SIZE_MAX) ? KEY_SIZE_MAX : ks_q;
  assign key_sel_o = key_sel;

  always_comb begin
    if (KEY_WORDS_BASE + int'(key_sel) > MAX_KEY_WORDS_COUNT) begin
      words = WRD_W'(MAX_KEY_WORDS_COUNT);
    end else begin
      words = WRD_W'(KEY_WORDS_BASE + int'(key_sel));
    end
  end

  // One key schedule round, with the round index as the key.
  assign ka = (rotr(w_q[1], ROT_X) + w_q[0]) ^ {{(WORD_W-CNT_W){1'b0}}, key_idx_i};
  assign kb = rotl(w_q[0], ROT_Y) ^ ka;

  assign w_shift[0] = kb;
  for (genvar j = 1; j < MAX_KEY_WORDS_COUNT; j++) begin : g_shift
    if (j < MAX_KEY_WORDS_COUNT - 1) begin : g_mid
      assign w_shift[j] = (WRD_W'(j + 1) == words) ? ka :
                          (WRD_W'(j + 1) <  words) ? w_q[j+1] : w_q[j];
    end else begin : g_last
      assign w_shift[j] = (WRD_W'(j + 1) == words) ? ka : w_q[j];
    end
  end

  for (genvar j = 0; j < MAX_KEY_WORDS_COUNT; j++) begin : g_wnext
    assign w_d[j] = cmd_i.key_load ? kw_q[j] :
                    cmd_i.key_step ? w_shift[j] : w_q[j];
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_KEY_WORDS_COUNT; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  assign kidx_inc  = key_idx_i + CNT_W'(1);
  assign ram_we    = cmd_i.key_load | cmd_i.key_step;
  assign ram_waddr = cmd_i.key_load ? '0 : kidx_inc[ADDR_W-1:0];
  assign ram_wdata = cmd_i.key_load ? kw_q[0] : kb;

  spk128_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_ROUNDS)
  ) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr_i),
    .rdata_o(rk)
  );

  assign xe = (rotr(x_q, ROT_X) + y_q) ^ rk;
  assign ye = rotl(y_q, ROT_Y) ^ xe;
  assign yd = rotr(y_q ^ x_q, ROT_Y);
  assign xd = rotl((x_q ^ rk) - yd, ROT_X);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cmd_i.load_blk) begin
      x_d = blk_i.block_high;
      y_d = blk_i.block_low;
    end else if (cmd_i.round_en) begin
      x_d = cmd_i.dec ? xd : xe;
      y_d = cmd_i.dec ? yd : ye;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
  end

  assign result_o.result_low  = y_q;
  assign result_o.result_high = x_q;

endmodule

// File: rtl/spk128_ctrl.sv
// ----------------------------------------------------------------------------
// Speck128 controller
// Sequences key expansion after reset and key writes, and the block rounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "speck128_block_cipher_top_assert.svh"

module spk128_ctrl #(
  parameter int MAX_ROUNDS = spk128_pkg::ROUNDS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              op_i,
  input  logic                              cfg_we_i,
  input  logic [spk128_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spk128_pkg::KEY_SIZE_W-1:0] key_sel_i,
  output logic                              busy_o,
  output logic                              done_o,
  output spk128_pkg::dp_cmd_t               cmd_o,
  output logic [$clog2(MAX_ROUNDS)-1:0]     rd_addr_o,
  output logic [$clog2(MAX_ROUNDS+1)-1:0]   key_idx_o
);

  import spk128_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROUNDS);
  localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);

  localparam logic [1:0] ST_KLOAD = 2'd0;
  localparam logic [1:0] ST_KEXP  = 2'd1;
  localparam logic [1:0] ST_IDLE  = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             dec_q, dec_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] rounds;
  logic [CNT_W-1:0] rounds_m1;
  logic [CNT_W-1:0] rounds_m2;
  logic             cfg_hit;
  logic             last;

  always_comb begin
    if (ROUND_BASE + int'(key_sel_i) > MAX_ROUNDS) begin
      rounds = CNT_W'(MAX_ROUNDS);
    end else begin
      rounds = CNT_W'(ROUND_BASE + int'(key_sel_i));
    end
  end

  assign rounds_m1 = rounds - CNT_W'(1);
  assign rounds_m2 = rounds - CNT_W'(2);
  assign cfg_hit   = cfg_we_i && (cfg_idx_i <= REG_KEY_WORD3);
  assign last      = dec_q ? (idx_q == '0) : (idx_q == rounds_m1);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    dec_d     = dec_q;
    done_d    = 1'b0;
    cmd_o     = '0;
    rd_addr_o = idx_q[ADDR_W-1:0];
    unique case (state_q)
      ST_KLOAD: begin
        cmd_o.key_load = 1'b1;
        idx_d          = '0;
        state_d        = ST_KEXP;
      end
      ST_KEXP: begin
        cmd_o.key_step = 1'b1;
        if (idx_q == rounds_m2) begin
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_blk = 1'b1;
          dec_d          = op_i;
          idx_d          = op_i ? rounds_m1 : '0;
          rd_addr_o      = idx_d[ADDR_W-1:0];
          state_d        = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.round_en = 1'b1;
        cmd_o.dec      = dec_q;
        if (last) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          idx_d     = dec_q ? (idx_q - CNT_W'(1)) : (idx_q + CNT_W'(1));
          rd_addr_o = idx_d[ADDR_W-1:0];
        end
      end
    endcase
    if (cfg_hit) begin
      state_d = ST_KLOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_KLOAD;
      idx_q   <= '0;
      dec_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      dec_q   <= dec_d;
      done_q  <= done_d;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign key_idx_o = idx_q;

  `SPK_ASSERT_SAME(a_run_idx_range, state_q == ST_RUN, idx_q < rounds, "round index out of range")
  `SPK_ASSERT_SAME(a_kexp_idx_range, state_q == ST_KEXP, idx_q <= rounds_m2, "key step overrun")
  `SPK_ASSERT_SAME(a_done_after_run, done_q, $past(state_q) == ST_RUN, "result without rounds")
  `SPK_ASSERT_NEXT(a_start_runs, state_q == ST_IDLE && start_i && !cfg_hit, state_q == ST_RUN, "item not started")

endmodule

// File: rtl/speck128_block_cipher_top.sv
// ----------------------------------------------------------------------------
// Speck128 block cipher top level
// Each item runs R rounds, where R is 32, 33 or 34 for 128, 192 or 256-bit keys,
// and its result shows with result_valid high for one cycle.
// A new item is taken only once the last one's rounds are done; the single round unit
// runs one round per cycle off the registered read of the round-key RAM.
// Reset, and every key register write, runs key expansion with busy
// high; no item is accepted until it ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module speck128_block_cipher_top #(
  parameter int MAX_ROUNDS          = spk128_pkg::ROUNDS_DEFAULT,
  parameter int MAX_KEY_WORDS_COUNT = spk128_pkg::KEY_WORDS_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  spk128_pkg::in_item_t             in_item_i,
  output logic                             result_valid_o,
  output spk128_pkg::out_item_t            result_o,
  input  logic                             cfg_we_i,
  input  logic [spk128_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spk128_pkg::WORD_W-1:0]    cfg_wdata_i
);

  import spk128_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ROUNDS);
  localparam int CNT_W  = $clog2(MAX_ROUNDS + 1);

  dp_cmd_t               cmd;
  logic [ADDR_W-1:0]     rd_addr;
  logic [CNT_W-1:0]      key_idx;
  logic [KEY_SIZE_W-1:0] key_sel;

  spk128_ctrl #(
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .op_i     (in_item_i.op),
    .cfg_we_i (cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .key_sel_i(key_sel),
    .busy_o   (busy_o),
    .done_o   (result_valid_o),
    .cmd_o    (cmd),
    .rd_addr_o(rd_addr),
    .key_idx_o(key_idx)
  );

  spk128_datapath #(
    .MAX_ROUNDS         (MAX_ROUNDS),
    .MAX_KEY_WORDS_COUNT(MAX_KEY_WORDS_COUNT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .key_idx_i  (key_idx),
    .blk_i      (in_item_i),
    .key_sel_o  (key_sel),
    .result_o   (result_o)
  );

endmodule
